// ===== design/nccp_pkg.sv =====
// nccp_pkg: shared widths, codes and control/status structs of the
// normalized cross-correlation peak search. No dependencies.
package nccp_pkg;

  localparam int MaxSamples = 256;
  localparam int SampleW    = 16;
  localparam int LagW       = 10;
  localparam int CoefW      = 16;

  localparam int AddrW     = $clog2(MaxSamples);
  localparam int CntW      = $clog2(MaxSamples + 1);
  localparam int SumW      = SampleW + CntW;
  localparam int DevW      = SampleW + CntW + 1;
  localparam int ProdW     = 2 * DevW;
  localparam int AccW      = ProdW + CntW;
  localparam int HalfW     = (AccW + 1) / 2;
  localparam int OpW       = 2 * HalfW;
  localparam int WideW     = 2 * OpW;
  localparam int RootW     = WideW + 2 * CoefW;
  localparam int KW        = $clog2(CoefW);
  localparam int RootShift = 2 * (CoefW - 1);
  localparam int IdxW      = (CntW + 2 > LagW) ? CntW + 2 : LagW;

  localparam logic [CntW-1:0]  MaxCnt  = CntW'(MaxSamples);
  localparam logic [CoefW-1:0] CoefMax = {1'b0, {(CoefW - 1){1'b1}}};

  typedef enum logic {
    MODE_ENERGY,
    MODE_CROSS
  } mode_e;

  typedef enum logic {
    MUL_SEL_NORM,
    MUL_SEL_PEAK
  } mul_sel_e;

  typedef struct packed {
    logic                   vld;
    mode_e                  mode;
    logic                   first;
    logic                   last;
    logic                   first_lag;
    logic [AddrW-1:0]       i;
    logic [AddrW-1:0]       j;
    logic signed [LagW-1:0] lag;
  } issue_t;

  typedef struct packed {
    logic          store;
    logic          clear;
    issue_t        issue;
    logic          mul_start;
    mul_sel_e      mul_sel;
    logic          root_init;
    logic          root_trial;
    logic          root_commit;
    logic [KW-1:0] root_k;
    logic          out_load;
  } cmd_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            pipe_busy;
    logic            degen;
    logic            mul_done;
  } sts_t;

endpackage

// ===== design/nccp_smp_if.sv =====
// nccp_smp_if: input channel carrying one sample pair word.
// Depends on nccp_pkg.
interface nccp_smp_if;
  logic                         valid;
  logic                         ready;
  logic [nccp_pkg::SampleW-1:0] ref_sample;
  logic [nccp_pkg::SampleW-1:0] cmp_sample;
  logic                         last;

  modport source (output valid, ref_sample, cmp_sample, last, input ready);
  modport sink (input valid, ref_sample, cmp_sample, last, output ready);
endinterface

// ===== design/nccp_res_if.sv =====
// nccp_res_if: output channel carrying one peak result word.
// Depends on nccp_pkg.
interface nccp_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [nccp_pkg::LagW-1:0]  best_lag;
  logic signed [nccp_pkg::CoefW-1:0] max_coef;
  logic                              degenerate;

  modport source (output valid, best_lag, max_coef, degenerate, input ready);
  modport sink (input valid, best_lag, max_coef, degenerate, output ready);
endinterface

// ===== design/nccp_wmul.sv =====
// nccp_wmul: wide unsigned multiplier built from four half-width partial
// products, one per cycle, accumulated in a register. Depends on nccp_pkg.
module nccp_wmul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [nccp_pkg::OpW-1:0]   a_i,
  input  logic [nccp_pkg::OpW-1:0]   b_i,
  output logic [nccp_pkg::WideW-1:0] prod_o,
  output logic                       done_o
);

  logic [2:0]                     step_q;
  logic                           busy_q;
  logic                           pp_vld_q;
  logic                           done_q;
  logic [1:0]                     pp_sh_q;
  logic [nccp_pkg::OpW-1:0]       pp_q;
  logic [nccp_pkg::WideW-1:0]     acc_q;
  logic [nccp_pkg::HalfW-1:0]     a_half;
  logic [nccp_pkg::HalfW-1:0]     b_half;
  logic [nccp_pkg::WideW-1:0]     pp_ext;

  always_comb begin
    a_half = step_q[0] ? a_i[nccp_pkg::OpW-1:nccp_pkg::HalfW] : a_i[nccp_pkg::HalfW-1:0];
    b_half = step_q[1] ? b_i[nccp_pkg::OpW-1:nccp_pkg::HalfW] : b_i[nccp_pkg::HalfW-1:0];
    pp_ext = nccp_pkg::WideW'(pp_q);
    unique case (pp_sh_q)
      2'd0:    pp_ext = nccp_pkg::WideW'(pp_q);
      2'd1:    pp_ext = nccp_pkg::WideW'(pp_q) << nccp_pkg::HalfW;
      2'd2:    pp_ext = nccp_pkg::WideW'(pp_q) << (2 * nccp_pkg::HalfW);
      default: pp_ext = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      step_q   <= '0;
      pp_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q   <= 1'b1;
        step_q   <= '0;
        pp_vld_q <= 1'b0;
      end else if (busy_q) begin
        if (!step_q[2]) begin
          step_q   <= step_q + 3'd1;
          pp_vld_q <= 1'b1;
        end else begin
          pp_vld_q <= 1'b0;
          busy_q   <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
    end else if (pp_vld_q) begin
      acc_q <= acc_q + pp_ext;
    end
    if (busy_q && !step_q[2]) begin
      pp_q    <= a_half * b_half;
      pp_sh_q <= {1'b0, step_q[0]} + {1'b0, step_q[1]};
    end
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

// ===== design/nccp_dp.sv =====
// nccp_dp: sample stores, running sums, centred product pipeline,
// accumulators, wide products, bit-serial coefficient root and result register.
// Depends on nccp_pkg and nccp_wmul.
module nccp_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  nccp_pkg::cmd_t                    cmd_i,
  input  logic [nccp_pkg::SampleW-1:0]      ref_sample_i,
  input  logic [nccp_pkg::SampleW-1:0]      cmp_sample_i,
  output nccp_pkg::sts_t                    sts_o,
  output logic signed [nccp_pkg::LagW-1:0]  best_lag_o,
  output logic signed [nccp_pkg::CoefW-1:0] max_coef_o,
  output logic                              degenerate_o
);

  logic [nccp_pkg::SampleW-1:0] ref_mem [nccp_pkg::MaxSamples];
  logic [nccp_pkg::SampleW-1:0] cmp_mem [nccp_pkg::MaxSamples];

  logic [nccp_pkg::CntW-1:0] count_q;
  logic [nccp_pkg::SumW-1:0] ref_sum_q;
  logic [nccp_pkg::SumW-1:0] cmp_sum_q;
  logic                      room;

  logic [nccp_pkg::SampleW-1:0] x_rd_q;
  logic [nccp_pkg::SampleW-1:0] y_rd_q;
  nccp_pkg::issue_t             s1_q, s2_q, s3_q;

  logic [nccp_pkg::SumW-1:0]          nx, ny;
  logic signed [nccp_pkg::DevW-1:0]   dx_q, dy_q;
  logic signed [nccp_pkg::ProdW-1:0]  pxy_q, pxx_q, pyy_q;
  logic signed [nccp_pkg::AccW-1:0]   sxx_q, syy_q, acc_q, best_q, acc_d;
  logic signed [nccp_pkg::LagW-1:0]   best_lag_q;
  logic                               degen;

  nccp_pkg::mul_sel_e             mul_sel_q;
  logic [nccp_pkg::AccW-1:0]      peak_abs;
  logic [nccp_pkg::OpW-1:0]       mul_a, mul_b;
  logic [nccp_pkg::WideW-1:0]     mul_prod;
  logic                           mul_done;

  logic [nccp_pkg::WideW-1:0]     p_q;
  logic [nccp_pkg::RootW-1:0]     r_q, s_q, t_q, sp_q, p_ext;
  logic [nccp_pkg::CoefW-1:0]     q_q;

  logic                              neg;
  logic signed [nccp_pkg::CoefW-1:0] coef_sel;
  logic signed [nccp_pkg::LagW-1:0]  neg_half;

  assign room = count_q < nccp_pkg::MaxCnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ref_sum_q <= '0;
      cmp_sum_q <= '0;
    end else if (cmd_i.clear) begin
      count_q   <= '0;
      ref_sum_q <= '0;
      cmp_sum_q <= '0;
    end else if (cmd_i.store && room) begin
      count_q   <= count_q + 1'b1;
      ref_sum_q <= ref_sum_q + nccp_pkg::SumW'(ref_sample_i);
      cmp_sum_q <= cmp_sum_q + nccp_pkg::SumW'(cmp_sample_i);
    end
  end

  // stores: one write, one registered read per memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && room) begin
      ref_mem[count_q[nccp_pkg::AddrW-1:0]] <= ref_sample_i;
      cmp_mem[count_q[nccp_pkg::AddrW-1:0]] <= cmp_sample_i;
    end
    x_rd_q <= ref_mem[cmd_i.issue.i];
    y_rd_q <= cmp_mem[cmd_i.issue.j];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else begin
      s1_q <= cmd_i.issue;
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  // centred values kept as n*x - sum
  always_comb begin
    nx = count_q * x_rd_q;
    ny = count_q * y_rd_q;
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= $signed({1'b0, nx}) - $signed({1'b0, ref_sum_q});
    dy_q  <= $signed({1'b0, ny}) - $signed({1'b0, cmp_sum_q});
    pxy_q <= dx_q * dy_q;
    pxx_q <= dx_q * dx_q;
    pyy_q <= dy_q * dy_q;
  end

  assign acc_d = (s3_q.first ? '0 : acc_q) + nccp_pkg::AccW'(pxy_q);

  always_ff @(posedge clk_i) begin
    if (s3_q.vld) begin
      if (s3_q.mode == nccp_pkg::MODE_ENERGY) begin
        sxx_q <= (s3_q.first ? '0 : sxx_q) + nccp_pkg::AccW'(pxx_q);
        syy_q <= (s3_q.first ? '0 : syy_q) + nccp_pkg::AccW'(pyy_q);
      end else begin
        acc_q <= acc_d;
        // strict compare keeps the earliest lag on ties
        if (s3_q.last && (s3_q.first_lag || acc_d > best_q)) begin
          best_q     <= acc_d;
          best_lag_q <= s3_q.lag;
        end
      end
    end
  end

  assign degen = (count_q < nccp_pkg::CntW'(2)) || (sxx_q == '0) || (syy_q == '0);

  // wide products: sxx*syy, then peak squared
  assign neg      = best_q[nccp_pkg::AccW-1];
  assign peak_abs = neg ? $unsigned(-best_q) : $unsigned(best_q);

  always_comb begin
    if (mul_sel_q == nccp_pkg::MUL_SEL_NORM) begin
      mul_a = nccp_pkg::OpW'($unsigned(sxx_q));
      mul_b = nccp_pkg::OpW'($unsigned(syy_q));
    end else begin
      mul_a = nccp_pkg::OpW'(peak_abs);
      mul_b = nccp_pkg::OpW'(peak_abs);
    end
  end

  nccp_wmul u_wmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_prod),
    .done_o (mul_done)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      mul_sel_q <= cmd_i.mul_sel;
    end
    if (mul_done) begin
      if (mul_sel_q == nccp_pkg::MUL_SEL_NORM) begin
        p_q <= mul_prod;
      end else begin
        r_q <= nccp_pkg::RootW'(mul_prod) << nccp_pkg::RootShift;
      end
    end
  end

  // root: largest q with q^2 * p <= r, one bit per trial/commit pair
  assign p_ext = nccp_pkg::RootW'(p_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_init) begin
      s_q <= '0;
      t_q <= '0;
      q_q <= '0;
    end
    if (cmd_i.root_trial) begin
      sp_q <= s_q + (t_q << ({1'b0, cmd_i.root_k} + 1'b1))
                  + (p_ext << {cmd_i.root_k, 1'b0});
    end
    if (cmd_i.root_commit && (sp_q <= r_q)) begin
      s_q               <= sp_q;
      t_q               <= t_q + (p_ext << cmd_i.root_k);
      q_q[cmd_i.root_k] <= 1'b1;
    end
  end

  assign neg_half = -$signed(nccp_pkg::LagW'(count_q >> 1));

  always_comb begin
    if (neg) begin
      coef_sel = -$signed(q_q);
    end else if (q_q[nccp_pkg::CoefW-1]) begin
      coef_sel = $signed(nccp_pkg::CoefMax);
    end else begin
      coef_sel = $signed(q_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      degenerate_o <= degen;
      best_lag_o   <= degen ? neg_half : best_lag_q;
      max_coef_o   <= degen ? '0 : coef_sel;
    end
  end

  always_comb begin
    sts_o.count     = count_q;
    sts_o.pipe_busy = s1_q.vld || s2_q.vld || s3_q.vld;
    sts_o.degen     = degen;
    sts_o.mul_done  = mul_done;
  end

endmodule

// ===== design/nccp_ctrl.sv =====
// nccp_ctrl: sequencer for sample loading, energy pass, lag search,
// wide products, root iterations and result handoff. Depends on nccp_pkg.
module nccp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  output logic           in_ready_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  input  nccp_pkg::sts_t sts_i,
  output nccp_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_E_ISSUE,
    ST_E_DRAIN,
    ST_X_ISSUE,
    ST_X_DRAIN,
    ST_MUL_P_GO,
    ST_MUL_P_WAIT,
    ST_MUL_C_GO,
    ST_MUL_C_WAIT,
    ST_ROOT_INIT,
    ST_ROOT_TRY,
    ST_ROOT_CMP,
    ST_OUT
  } state_e;

  state_e                           state_q;
  logic [nccp_pkg::CntW-1:0]        i_q;
  logic signed [nccp_pkg::LagW-1:0] lag_q;
  logic                             first_q;
  logic [nccp_pkg::KW-1:0]          k_q;
  logic                             out_vld_q;

  logic [nccp_pkg::CntW-1:0]        n, half;
  logic signed [nccp_pkg::IdxW-1:0] n_s, half_s, lag_s, lag_nx_s, i_s, j_s;
  logic signed [nccp_pkg::IdxW-1:0] neg_half_s, i_end_s, start_nx_s;
  logic                             e_last, x_last, lag_final, load;

  always_comb begin
    n          = sts_i.count;
    half       = n >> 1;
    n_s        = $signed(nccp_pkg::IdxW'(n));
    half_s     = $signed(nccp_pkg::IdxW'(half));
    neg_half_s = -half_s;
    lag_s      = nccp_pkg::IdxW'(lag_q);
    lag_nx_s   = lag_s + nccp_pkg::IdxW'(1);
    i_s        = $signed(nccp_pkg::IdxW'(i_q));
    j_s        = i_s + lag_s;
    // overlap of lag d: i from max(0,-d) to min(n,n-d)-1
    i_end_s    = (lag_s < 0) ? n_s - nccp_pkg::IdxW'(1) : n_s - nccp_pkg::IdxW'(1) - lag_s;
    start_nx_s = (lag_nx_s < 0) ? -lag_nx_s : '0;
    e_last     = i_q == n - 1'b1;
    x_last     = i_s == i_end_s;
    lag_final  = lag_s == half_s - nccp_pkg::IdxW'(1);
    load       = (state_q == ST_OUT) && (!out_vld_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      i_q       <= '0;
      lag_q     <= '0;
      first_q   <= 1'b0;
      k_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_last_i) begin
            state_q <= ST_E_ISSUE;
            i_q     <= '0;
          end
        end
        ST_E_ISSUE: begin
          i_q <= i_q + 1'b1;
          if (e_last) begin
            state_q <= ST_E_DRAIN;
          end
        end
        ST_E_DRAIN: begin
          if (!sts_i.pipe_busy) begin
            if (sts_i.degen) begin
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_X_ISSUE;
              lag_q   <= nccp_pkg::LagW'(neg_half_s);
              i_q     <= half;
              first_q <= 1'b1;
            end
          end
        end
        ST_X_ISSUE: begin
          first_q <= 1'b0;
          i_q     <= i_q + 1'b1;
          if (x_last) begin
            if (lag_final) begin
              state_q <= ST_X_DRAIN;
            end else begin
              lag_q   <= lag_q + 1'b1;
              i_q     <= nccp_pkg::CntW'(start_nx_s);
              first_q <= 1'b1;
            end
          end
        end
        ST_X_DRAIN: begin
          if (!sts_i.pipe_busy) begin
            state_q <= ST_MUL_P_GO;
          end
        end
        ST_MUL_P_GO: state_q <= ST_MUL_P_WAIT;
        ST_MUL_P_WAIT: begin
          if (sts_i.mul_done) begin
            state_q <= ST_MUL_C_GO;
          end
        end
        ST_MUL_C_GO: state_q <= ST_MUL_C_WAIT;
        ST_MUL_C_WAIT: begin
          if (sts_i.mul_done) begin
            state_q <= ST_ROOT_INIT;
            k_q     <= nccp_pkg::KW'(nccp_pkg::CoefW - 1);
          end
        end
        ST_ROOT_INIT: state_q <= ST_ROOT_TRY;
        ST_ROOT_TRY:  state_q <= ST_ROOT_CMP;
        ST_ROOT_CMP: begin
          if (k_q == '0) begin
            state_q <= ST_OUT;
          end else begin
            k_q     <= k_q - 1'b1;
            state_q <= ST_ROOT_TRY;
          end
        end
        ST_OUT: begin
          if (load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o                 = '0;
    cmd_o.store           = in_valid_i && (state_q == ST_IDLE);
    cmd_o.clear           = load;
    cmd_o.issue.vld       = (state_q == ST_E_ISSUE) || (state_q == ST_X_ISSUE);
    cmd_o.issue.mode      = (state_q == ST_X_ISSUE) ? nccp_pkg::MODE_CROSS
                                                    : nccp_pkg::MODE_ENERGY;
    cmd_o.issue.first     = (state_q == ST_X_ISSUE) ? first_q : (i_q == '0);
    cmd_o.issue.last      = (state_q == ST_X_ISSUE) ? x_last : e_last;
    cmd_o.issue.first_lag = lag_s == neg_half_s;
    cmd_o.issue.i         = i_q[nccp_pkg::AddrW-1:0];
    cmd_o.issue.j         = (state_q == ST_X_ISSUE) ? j_s[nccp_pkg::AddrW-1:0]
                                                    : i_q[nccp_pkg::AddrW-1:0];
    cmd_o.issue.lag       = lag_q;
    cmd_o.mul_start       = (state_q == ST_MUL_P_GO) || (state_q == ST_MUL_C_GO);
    cmd_o.mul_sel         = (state_q == ST_MUL_C_GO) ? nccp_pkg::MUL_SEL_PEAK
                                                     : nccp_pkg::MUL_SEL_NORM;
    cmd_o.root_init       = state_q == ST_ROOT_INIT;
    cmd_o.root_trial      = state_q == ST_ROOT_TRY;
    cmd_o.root_commit     = state_q == ST_ROOT_CMP;
    cmd_o.root_k          = k_q;
    cmd_o.out_load        = load;
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_vld_q;

  a_cross_not_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_X_ISSUE) |-> !sts_i.degen)
    else $error("lag search running on a degenerate series");

  a_mul_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.mul_done |-> (state_q == ST_MUL_P_WAIT || state_q == ST_MUL_C_WAIT))
    else $error("wide product finished outside a wait state");

  a_root_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT_CMP && k_q == '0) |=> (state_q == ST_OUT))
    else $error("root iterations did not end at the last bit");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (out_vld_q && state_q == ST_IDLE && sts_i.count == '0))
    else $error("result load did not present a word and clear the series");

endmodule

// ===== design/normalized_cross_correlation_peak_top.sv =====
// normalized_cross_correlation_peak_top: top level joining controller and
// datapath. Depends on nccp_pkg, nccp_smp_if, nccp_res_if, nccp_ctrl, nccp_dp.
//
// Usage: sample pair words arrive on smp_i (ref_sample, cmp_sample, last).
// While loading, one word is taken per cycle; pairs beyond MaxSamples are
// dropped, a dropped word with last still closes the series. After the word
// with last, ready stays low while the search runs; one result word then
// appears on res_o (best_lag, max_coef, degenerate).
// After last, with n stored pairs: an energy pass over the n pairs, then
// a lag search that sums the overlap length of each lag at one centred
// product per cycle through the single read port of each sample store,
// then a pipeline drain, two wide products and the bit-serial root.
// A degenerate series skips everything after the energy pass.
// Reset clears counts and sums; the sample stores need no clearing pass.
// The result sits in an output register: a stalled receiver does not stop
// the next series from loading, but the next result waits until the present
// one is taken.
module normalized_cross_correlation_peak_top (
  input logic        clk_i,
  input logic        rst_ni,
  nccp_smp_if.sink   smp_i,
  nccp_res_if.source res_o
);

  nccp_pkg::cmd_t cmd;
  nccp_pkg::sts_t sts;
  logic           in_ready;
  logic           out_valid;

  nccp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (smp_i.valid),
    .in_last_i  (smp_i.last),
    .in_ready_o (in_ready),
    .out_ready_i(res_o.ready),
    .out_valid_o(out_valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nccp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .ref_sample_i(smp_i.ref_sample),
    .cmp_sample_i(smp_i.cmp_sample),
    .sts_o       (sts),
    .best_lag_o  (res_o.best_lag),
    .max_coef_o  (res_o.max_coef),
    .degenerate_o(res_o.degenerate)
  );

  assign smp_i.ready = in_ready;
  assign res_o.valid = out_valid;

endmodule

// ===== tb/sv/nccp_peak_checker.sv =====
// nccp_peak_checker: watches the sample and result channels of the
// correlation peak search, predicts each peak word and compares it.
// Depends on nccp_pkg, nccp_smp_if and nccp_res_if.
module nccp_peak_checker (
  input  logic clk_i,
  input  logic rst_ni,
  nccp_smp_if  smp,
  nccp_res_if  res,
  output int   mismatch_cnt_o,
  output int   peaks_waiting_o,
  output int   words_in_o,
  output int   peaks_out_o,
  output int   degen_seen_o
);

  typedef struct packed {
    logic signed [nccp_pkg::LagW-1:0]  lag;
    logic signed [nccp_pkg::CoefW-1:0] coef;
    logic                              degen;
  } peak_t;

  logic [nccp_pkg::SampleW-1:0] ref_mem [nccp_pkg::MaxSamples];
  logic [nccp_pkg::SampleW-1:0] cmp_mem [nccp_pkg::MaxSamples];
  int                           n_stored;
  longint                       ref_total;
  longint                       cmp_total;
  peak_t                        peak_q[$];

  assign peaks_waiting_o = peak_q.size();

  // largest q in 0..32768 with q^2 * sxx * syy <= 2^30 * c^2
  function automatic int unsigned coef_magnitude(longint c, longint sxx, longint syy);
    logic [191:0] rhs;
    logic [191:0] energy;
    logic [191:0] lhs;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    rhs    = (192'(c) * 192'(c)) << 30;
    energy = 192'(sxx) * 192'(syy);
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = 192'(mid) * 192'(mid) * energy;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic peak_t search_peak();
    peak_t       p;
    longint      nn;
    longint      dx;
    longint      dy;
    longint      sxx;
    longint      syy;
    longint      acc;
    longint      best;
    int          half;
    int          best_lag;
    int          j;
    int unsigned q;
    nn   = n_stored;
    half = n_stored / 2;
    sxx  = 0;
    syy  = 0;
    best = 0;
    for (int i = 0; i < n_stored; i++) begin
      dx = nn * ref_mem[i] - ref_total;
      dy = nn * cmp_mem[i] - cmp_total;
      sxx += dx * dx;
      syy += dy * dy;
    end
    p.degen  = (n_stored < 2) || (sxx == 0) || (syy == 0);
    best_lag = -half;
    p.coef   = '0;
    if (!p.degen) begin
      for (int lag = -half; lag < half; lag++) begin
        acc = 0;
        for (int i = 0; i < n_stored; i++) begin
          j = i + lag;
          if (j >= 0 && j < n_stored)
            acc += (nn * ref_mem[i] - ref_total) * (nn * cmp_mem[j] - cmp_total);
        end
        // first lag wins on ties
        if (lag == -half || acc > best) begin
          best     = acc;
          best_lag = lag;
        end
      end
      if (best >= 0) begin
        q = coef_magnitude(best, sxx, syy);
        p.coef = (q > 32767) ? nccp_pkg::CoefMax : nccp_pkg::CoefW'(q);
      end else begin
        q = coef_magnitude(-best, sxx, syy);
        p.coef = -nccp_pkg::CoefW'(q);
      end
    end
    p.lag = nccp_pkg::LagW'(best_lag);
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    peak_t want;
    if (!rst_ni) begin
      n_stored        = 0;
      ref_total       = 0;
      cmp_total       = 0;
      mismatch_cnt_o <= 0;
      words_in_o     <= 0;
      peaks_out_o    <= 0;
      degen_seen_o   <= 0;
      peak_q.delete();
    end else begin
      if (smp.valid && smp.ready) begin
        words_in_o <= words_in_o + 1;
        // pairs beyond a full store are dropped
        if (n_stored < nccp_pkg::MaxSamples) begin
          ref_mem[n_stored] = smp.ref_sample;
          cmp_mem[n_stored] = smp.cmp_sample;
          ref_total = ref_total + smp.ref_sample;
          cmp_total = cmp_total + smp.cmp_sample;
          n_stored  = n_stored + 1;
        end
        if (smp.last) begin
          peak_q.insert(peak_q.size(), search_peak());
          n_stored  = 0;
          ref_total = 0;
          cmp_total = 0;
        end
      end
      if (res.valid && res.ready) begin
        peaks_out_o <= peaks_out_o + 1;
        if (res.degenerate) degen_seen_o <= degen_seen_o + 1;
        if (peak_q.size() == 0) begin
          $display("%0t: peak word with none expected: lag %0d coef %0d degen %0b",
                   $time, res.best_lag, res.max_coef, res.degenerate);
          mismatch_cnt_o <= mismatch_cnt_o + 1;
        end else begin
          want = peak_q.pop_front();
          if (res.best_lag !== want.lag || res.max_coef !== want.coef
              || res.degenerate !== want.degen) begin
            $display("%0t: peak mismatch: expected lag %0d coef %0d degen %0b,",
                     $time, want.lag, want.coef, want.degen);
            $display("%0t:   actual lag %0d coef %0d degen %0b",
                     $time, res.best_lag, res.max_coef, res.degenerate);
            mismatch_cnt_o <= mismatch_cnt_o + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb_normalized_cross_correlation_peak_top.sv =====
// tb_normalized_cross_correlation_peak_top: drives sample series into the
// correlation peak search and gives the verdict; checking is in nccp_peak_checker.
// Depends on nccp_pkg, the two channel interfaces, the top level and the checker.
module tb_normalized_cross_correlation_peak_top;

  localparam int WatchdogLimit = 400000;
  localparam int HoldCycles    = 1500;

  // shapes of a generated series
  localparam int ShapeRandom    = 0;
  localparam int ShapeNarrow    = 1;
  localparam int ShapeFlatRef   = 2;
  localparam int ShapeFlatCmp   = 3;
  localparam int ShapeSame      = 4;
  localparam int ShapeShifted   = 5;
  localparam int ShapeAlternate = 6;
  localparam int ShapeExtremes  = 7;
  localparam int ShapeInverse   = 8;

  logic clk_i;
  logic rst_ni;
  int   mismatch_cnt;
  int   peaks_waiting;
  int   words_in;
  int   peaks_out;
  int   degen_seen;
  int   idle_cycles;
  int   burst_left;
  logic gaps_on;
  logic hold_go;

  nccp_smp_if smp ();
  nccp_res_if res ();

  normalized_cross_correlation_peak_top u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .smp_i (smp),
    .res_o (res)
  );

  nccp_peak_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .smp            (smp),
    .res            (res),
    .mismatch_cnt_o (mismatch_cnt),
    .peaks_waiting_o(peaks_waiting),
    .words_in_o     (words_in),
    .peaks_out_o    (peaks_out),
    .degen_seen_o   (degen_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver: random stall pattern, always-ready stretches, one long hold
  initial begin
    int   phase_left;
    int   ready_pct;
    int   hold_left;
    logic hold_done;
    res.ready  = 1'b0;
    phase_left = 0;
    ready_pct  = 100;
    hold_left  = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(16, 96);
        case ($urandom_range(0, 2))
          0: ready_pct = 100;
          1: ready_pct = 60;
          default: ready_pct = 15;
        endcase
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk_i) begin
    if ((smp.valid && smp.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("[normalized_cross_correlation_peak_top] ERROR");
      $finish;
    end
  end

  task automatic send_pair(input logic [nccp_pkg::SampleW-1:0] x,
                           input logic [nccp_pkg::SampleW-1:0] y,
                           input logic is_last);
    if (gaps_on && burst_left == 0) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    smp.valid      <= 1'b1;
    smp.ref_sample <= x;
    smp.cmp_sample <= y;
    smp.last       <= is_last;
    do @(posedge clk_i); while (!smp.ready);
  endtask

  task automatic send_series(input int len, input int shape);
    logic [nccp_pkg::SampleW-1:0] xs[$];
    logic [nccp_pkg::SampleW-1:0] ys[$];
    logic [nccp_pkg::SampleW-1:0] base;
    logic [nccp_pkg::SampleW-1:0] v;
    logic [nccp_pkg::SampleW-1:0] xv;
    logic [nccp_pkg::SampleW-1:0] yv;
    int                           shift;
    base  = nccp_pkg::SampleW'($urandom);
    shift = $urandom_range(0, (len > 2) ? len / 2 : 1);
    for (int i = 0; i < len; i++) begin
      case (shape)
        ShapeNarrow: begin
          xv = nccp_pkg::SampleW'($urandom_range(0, 3));
          yv = nccp_pkg::SampleW'($urandom_range(0, 3));
        end
        ShapeFlatRef: begin
          xv = base;
          yv = nccp_pkg::SampleW'($urandom);
        end
        ShapeFlatCmp: begin
          xv = nccp_pkg::SampleW'($urandom);
          yv = base;
        end
        ShapeSame: begin
          v  = nccp_pkg::SampleW'($urandom);
          xv = v;
          yv = v;
        end
        ShapeAlternate: begin
          xv = (i % 2) ? 16'hffff : 16'h0000;
          yv = (i % 2) ? 16'h0000 : 16'hffff;
        end
        ShapeExtremes: begin
          xv = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
          yv = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        end
        ShapeInverse: begin
          v  = nccp_pkg::SampleW'($urandom);
          xv = v;
          yv = ~v;
        end
        default: begin
          xv = nccp_pkg::SampleW'($urandom);
          yv = nccp_pkg::SampleW'($urandom);
        end
      endcase
      xs.insert(i, xv);
      ys.insert(i, yv);
    end
    // compared series delayed by shift samples: strong peak at that lag where the search covers it
    if (shape == ShapeShifted)
      for (int i = 0; i < len; i++)
        ys[i] = (i >= shift) ? xs[i - shift] : nccp_pkg::SampleW'($urandom);
    for (int i = 0; i < len; i++) send_pair(xs[i], ys[i], i == len - 1);
  endtask

  task automatic wait_drained();
    smp.valid <= 1'b0;
    @(posedge clk_i);
    while (peaks_waiting != 0) @(posedge clk_i);
  endtask

  initial begin
    int len;
    int shape;
    rst_ni         = 1'b0;
    smp.valid      = 1'b0;
    smp.ref_sample = '0;
    smp.cmp_sample = '0;
    smp.last       = 1'b0;
    idle_cycles    = 0;
    burst_left     = 0;
    gaps_on        = 1'b0;
    hold_go        = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: single pair, exact +1.0, flat series, extremes, ties, inverse
    send_series(1, ShapeRandom);
    send_series(2, ShapeExtremes);
    send_series(2, ShapeSame);
    send_series(4, ShapeFlatRef);
    send_series(3, ShapeFlatCmp);
    send_series(4, ShapeAlternate);
    send_series(3, ShapeInverse);
    send_series(5, ShapeShifted);
    wait_drained();

    // receiver holds off while several series keep coming
    hold_go <= 1'b1;
    for (int s = 0; s < 5; s++) send_series(4, ShapeRandom);
    wait_drained();

    gaps_on = 1'b1;
    while (words_in < 240) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
      shape = $urandom_range(0, 8);
      if (shape == ShapeAlternate || shape == ShapeFlatRef) shape = $urandom_range(0, 8);
      send_series(len, shape);
      if ($urandom_range(0, 19) == 0) wait_drained();
    end

    // full store, then pairs past capacity with last on a dropped pair
    send_series(nccp_pkg::MaxSamples + 3, ShapeShifted);
    wait_drained();
    repeat (200) @(posedge clk_i);

    $display("sent %0d sample words, checked %0d peak words (%0d degenerate)",
             words_in, peaks_out, degen_seen);
    if (mismatch_cnt == 0 && peaks_waiting == 0) begin
      $display("[normalized_cross_correlation_peak_top] OK");
    end else begin
      $display("[normalized_cross_correlation_peak_top] ERROR");
    end
    $finish;
  end
endmodule

// ===== normalized_cross_correlation_peak_top.f =====
design/nccp_pkg.sv
design/nccp_smp_if.sv
design/nccp_res_if.sv
design/nccp_wmul.sv
design/nccp_dp.sv
design/nccp_ctrl.sv
design/normalized_cross_correlation_peak_top.sv
tb/sv/nccp_peak_checker.sv
tb/sv/tb_normalized_cross_correlation_peak_top.sv
